// File: rtl/lsee_pkg.sv
// ----------------------------------------------------------------------------
// LED strip effect engine package
// Shared types, constants and command codes.
// ----------------------------------------------------------------------------
package lsee_pkg;

  localparam int unsigned MaxLeds  = 256;
  localparam int unsigned AddrW    = 8;
  localparam int unsigned PixW     = 24;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 9;

  localparam logic [CfgIdxW-1:0] CFG_MAX_LEVEL    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRIP_LENGTH = 1'd1;

  typedef enum logic [2:0] {
    FUNC_SET     = 3'd0,
    FUNC_WHEEL   = 3'd1,
    FUNC_RAINBOW = 3'd2,
    FUNC_MOVE    = 3'd3,
    FUNC_READ    = 3'd4,
    FUNC_NOP5    = 3'd5,
    FUNC_NOP6    = 3'd6,
    FUNC_NOP7    = 3'd7
  } func_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] step_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       index_ok;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_WRITE1,
    ST_RB_DIV,
    ST_RB_WR,
    ST_MV_DIV,
    ST_MV_RD,
    ST_MV_WAIT,
    ST_MV_WR,
    ST_RD,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  // divider control
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  // seg is the quotient mod 6
  typedef struct packed {
    logic        done;
    logic [2:0]  seg;
    logic [8:0]  rem;
  } div_rsp_t;

endpackage

// File: rtl/lsee_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lsee_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/lsee_div.sv
// ----------------------------------------------------------------------------
// Shared divider
// Restoring radix-2 divider, 16-bit dividend by 9-bit divisor.
// The quotient mod 6 is accumulated as the quotient bits come out.
// ----------------------------------------------------------------------------
module lsee_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lsee_pkg::div_req_t req_i,
  output lsee_pkg::div_rsp_t rsp_o
);
  import lsee_pkg::*;

  logic [15:0] quot_q, quot_d;
  logic [8:0]  rem_q, rem_d;
  logic [8:0]  dvs_q, dvs_d;
  logic [2:0]  seg_q, seg_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [9:0]  trial;
  logic        qbit;
  logic [3:0]  seg_x;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    seg_d  = seg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quot_q[15]};
    qbit   = (trial >= {1'b0, dvs_q});
    seg_x  = {seg_q, qbit};
    if (req_i.start) begin
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      seg_d  = '0;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (qbit) begin
        rem_d = 9'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[14:0], 1'b1};
      end else begin
        rem_d = trial[8:0];
        quot_d = {quot_q[14:0], 1'b0};
      end
      seg_d = (seg_x >= 4'd6) ? 3'(seg_x - 4'd6) : seg_x[2:0];
      cnt_d = 5'(cnt_q + 5'd1);
      if (cnt_q == 5'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    seg_q  <= seg_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.seg  = seg_q;
  assign rsp_o.rem  = rem_q;

  ap_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("divider done held");
  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  ap_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= 5'd15) else $error("divider count overrun");

endmodule

// File: rtl/led_strip_effect_engine_core.sv
// ----------------------------------------------------------------------------
// LED strip effect engine core
// RGB frame buffer with set, wheel, rainbow, moving-dot and read commands.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; exactly one
// result follows as a one-cycle done_o strobe, which the receiver must take.
// After reset the block clears its 256-entry pixel memory, one entry a cycle,
// with busy_o high. After a transfer, a disabled strip or an unused code goes
// straight to the done state; set and an out-of-range index pass the range
// check first, read adds a memory read wait, and wheel color also waits on the
// divider (skipped when max_level is 0). done_o comes in the cycle in which
// busy_o drops. Rainbow runs the shared divider once per pixel in use (not
// when max_level is 0); move divides once and then reads and rewrites each
// pixel. The longest command is rainbow over 256 pixels.
module led_strip_effect_engine_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  lsee_pkg::cmd_t           cmd_i,
  output logic                     busy_o,
  output logic                     done_o,
  output lsee_pkg::rsp_t           rsp_o,
  input  logic                     cfg_we_i,
  input  logic [lsee_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsee_pkg::CfgDataW-1:0] cfg_data_i
);
  import lsee_pkg::*;

  state_e      state_q, state_d;
  logic [7:0]  max_q;
  logic [8:0]  len_q;
  cmd_t        cmd_q, cmd_d;
  logic [8:0]  ulen_q, ulen_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [8:0]  dotpos_q, dotpos_d;
  logic [23:0] dotcol_q, dotcol_d;
  rsp_t        rsp_q, rsp_d;
  logic        done_q, done_d;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        we;
  logic [AddrW-1:0] addr;
  logic [PixW-1:0]  wdata, rdata;

  logic [2:0]  seg;
  logic [7:0]  pos, mmp;
  logic [23:0] wheel_col;
  logic [8:0]  qpos;
  logic [7:0]  half;
  logic [15:0] rb_idx;

  lsee_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  lsee_ram #(.Width(PixW), .Depth(MaxLeds)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_LEVEL:    max_q <= cfg_data_i[7:0];
        CFG_STRIP_LENGTH: len_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign seg  = drsp.seg;
  assign pos  = drsp.rem[7:0];
  assign mmp  = 8'(max_q - pos);
  assign half = {1'b0, max_q[7:1]};
  assign qpos = seg[0] ? 9'(ulen_q - drsp.rem - 9'd1) : drsp.rem;
  assign rb_idx = 16'(cnt_q + cmd_q.step_value);

  always_comb begin
    unique case (seg)
      3'd0:    wheel_col = {max_q, pos, 8'd0};
      3'd1:    wheel_col = {mmp, max_q, 8'd0};
      3'd2:    wheel_col = {8'd0, max_q, pos};
      3'd3:    wheel_col = {8'd0, mmp, max_q};
      3'd4:    wheel_col = {pos, 8'd0, max_q};
      default: wheel_col = {max_q, 8'd0, mmp};
    endcase
    if (max_q == 8'd0) wheel_col = '0;
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    ulen_d   = ulen_q;
    cnt_d    = cnt_q;
    dotpos_d = dotpos_q;
    dotcol_d = dotcol_q;
    rsp_d    = rsp_q;
    done_d   = 1'b0;
    dreq     = '0;
    we       = 1'b0;
    addr     = cnt_q[AddrW-1:0];
    wdata    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        cnt_d = 9'(cnt_q + 9'd1);
        if (cnt_q == 9'(MaxLeds - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d  = cmd_i;
          ulen_d = (len_q > 9'(MaxLeds)) ? 9'(MaxLeds) : len_q;
          cnt_d  = '0;
          rsp_d  = '0;
          if (len_q == 9'd0) begin
            state_d = ST_DONE;
          end else begin
            unique case (func_e'(cmd_i.func))
              FUNC_SET, FUNC_READ: state_d = ST_RD;
              FUNC_WHEEL: state_d = ST_RD;
              FUNC_RAINBOW: begin
                dreq.start = (max_q != 8'd0);
                dreq.dividend = cmd_i.step_value;
                dreq.divisor = {1'b0, max_q};
                state_d = ST_RB_DIV;
              end
              FUNC_MOVE: begin
                dreq.start = 1'b1;
                dreq.dividend = cmd_i.step_value;
                dreq.divisor = (len_q > 9'(MaxLeds)) ? 9'(MaxLeds) : len_q;
                state_d = ST_MV_DIV;
              end
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_RD: begin
        // range check for single-pixel commands
        if ({7'd0, ulen_q} <= cmd_q.pixel_index) begin
          state_d = ST_DONE;
        end else begin
          rsp_d.index_ok = 1'b1;
          addr = cmd_q.pixel_index[AddrW-1:0];
          unique case (func_e'(cmd_q.func))
            FUNC_SET: begin
              we = 1'b1;
              wdata = {cmd_q.red, cmd_q.green, cmd_q.blue};
              state_d = ST_DONE;
            end
            FUNC_WHEEL: begin
              dreq.start = (max_q != 8'd0);
              dreq.dividend = cmd_q.step_value;
              dreq.divisor = {1'b0, max_q};
              state_d = ST_DIV;
            end
            default: state_d = ST_RD_WAIT;
          endcase
        end
      end
      ST_RD_WAIT: begin
        {rsp_d.out_red, rsp_d.out_green, rsp_d.out_blue} = rdata;
        state_d = ST_DONE;
      end
      ST_DIV: begin
        if (drsp.done || max_q == 8'd0) begin
          state_d = ST_WRITE1;
        end
      end
      ST_WRITE1: begin
        we = 1'b1;
        addr = cmd_q.pixel_index[AddrW-1:0];
        wdata = wheel_col;
        state_d = ST_DONE;
      end
      ST_RB_DIV: begin
        if (drsp.done || max_q == 8'd0) state_d = ST_RB_WR;
      end
      ST_RB_WR: begin
        we = 1'b1;
        wdata = wheel_col;
        cnt_d = 9'(cnt_q + 9'd1);
        if (9'(cnt_q + 9'd1) == ulen_q) begin
          rsp_d.index_ok = 1'b1;
          state_d = ST_DONE;
        end else begin
          dreq.start = (max_q != 8'd0);
          dreq.dividend = 16'(rb_idx + 16'd1);
          dreq.divisor = {1'b0, max_q};
          state_d = ST_RB_DIV;
        end
      end
      ST_MV_DIV: begin
        if (drsp.done) begin
          dotpos_d = qpos;
          unique case (seg)
            3'd0:    dotcol_d = {max_q, 16'd0};
            3'd1:    dotcol_d = {8'd0, max_q, 8'd0};
            3'd2:    dotcol_d = {16'd0, max_q};
            3'd3:    dotcol_d = {half, half, 8'd0};
            3'd4:    dotcol_d = {8'd0, half, half};
            default: dotcol_d = {half, 8'd0, half};
          endcase
          state_d = ST_MV_RD;
        end
      end
      ST_MV_RD: state_d = ST_MV_WAIT;
      ST_MV_WAIT: state_d = ST_MV_WR;
      ST_MV_WR: begin
        we = 1'b1;
        wdata = (cnt_q == dotpos_q) ? dotcol_q
              : {1'b0, rdata[23:17], 1'b0, rdata[15:9], 1'b0, rdata[7:1]};
        cnt_d = 9'(cnt_q + 9'd1);
        if (9'(cnt_q + 9'd1) == ulen_q) begin
          rsp_d.index_ok = 1'b1;
          state_d = ST_DONE;
        end else begin
          state_d = ST_MV_RD;
        end
      end
      ST_DONE: begin
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ulen_q   <= ulen_d;
    dotpos_q <= dotpos_d;
    dotcol_q <= dotcol_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = done_q ? rsp_q : '0;

  ap_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("result strobe held");
  ap_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE) else $error("result outside idle");
  ap_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !rsp_q.index_ok) |-> rsp_q.out_red == 8'd0 && rsp_q.out_blue == 8'd0)
    else $error("levels without valid index");
  ap_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !we) else $error("memory write while idle");

endmodule
